// File: rtl/mts_pkg.sv
// Shared types, constants and codes of the multi-timer scheduler.
package mts_pkg;

    // Default slot count and the largest table that a 5-bit slot number can address.
    localparam int TIMER_SLOTS_DEF = 32;
    localparam int SLOT_MAX        = 32;

    // Field widths.
    localparam int TIME_W    = 48;
    localparam int PERIOD_W  = 32;
    localparam int SLOT_ID_W = 5;
    localparam int FIRE_CNT_W = 6;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_ADD       = 2'd0,
        KIND_REMOVE    = 2'd1,
        KIND_FIRED     = 2'd2,
        KIND_IDLE_TICK = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_REM,
        ST_SCAN,
        ST_FIRE,
        ST_RESCHED,
        ST_EMIT
    } state_t;

    // Request to the slot memory: one write port and one read address.
    typedef struct packed {
        logic                  we;
        logic [SLOT_ID_W-1:0]  waddr;
        logic [TIME_W-1:0]     wdeadline;
        logic [PERIOD_W-1:0]   wperiod;
        logic [SLOT_ID_W-1:0]  raddr;
    } mem_req_t;

    // One slot entry as read from the memory.
    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
    } slot_entry_t;

    // Operands of the shared adder and comparator.
    typedef struct packed {
        logic [TIME_W-1:0]   add_a;
        logic [PERIOD_W-1:0] add_b;
        logic [TIME_W:0]     cmp_a;
        logic [TIME_W:0]     cmp_b;
    } arith_in_t;

    // Results of the shared adder and comparator.
    typedef struct packed {
        logic [TIME_W:0] sum;
        logic            lt;
        logic            eq;
    } arith_out_t;

endpackage

// File: rtl/mts_slot_mem.sv
// Deadline and period storage of the timer slots, one write and one registered read port.
module mts_slot_mem #(
    parameter int SLOT_COUNT = mts_pkg::TIMER_SLOTS_DEF
) (
    input  logic                  clk,
    input  mts_pkg::mem_req_t     req,
    output mts_pkg::slot_entry_t  rdata
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic [mts_pkg::TIME_W-1:0]   deadline_mem [SLOT_COUNT];
    logic [mts_pkg::PERIOD_W-1:0] period_mem   [SLOT_COUNT];
    mts_pkg::slot_entry_t         rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            deadline_mem[req.waddr[IDX_W-1:0]] <= req.wdeadline;
            period_mem[req.waddr[IDX_W-1:0]]   <= req.wperiod;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg.deadline <= deadline_mem[req.raddr[IDX_W-1:0]];
        rdata_reg.period   <= period_mem[req.raddr[IDX_W-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mts_arith.sv
// Shared deadline adder and magnitude comparator used by the add, scan, fire and reschedule steps of the sequencer.
module mts_arith (
    input  mts_pkg::arith_in_t  op_in,
    output mts_pkg::arith_out_t res
);

    // One 49-bit adder; the carry out is kept for the reschedule compare against now.
    assign res.sum = {1'b0, op_in.add_a}
                   + {{(mts_pkg::TIME_W + 1 - mts_pkg::PERIOD_W){1'b0}}, op_in.add_b};

    // One 49-bit compare.
    assign res.lt = (op_in.cmp_a < op_in.cmp_b);
    assign res.eq = (op_in.cmp_a == op_in.cmp_b);

endmodule

// File: rtl/multi_timer_scheduler.sv
// Timer table scheduler: sequencer, slot flags and output register.
// Add walks the slot flags for the lowest free slot; remove checks only the target slot.
// A tick walks the deadline memory once per fired slot through its single read port, reschedules
// a periodic slot and emits each result beat; one last walk, or the result limit, ends it.
// The block takes one item at a time, only while idle; a stalled output holds it in its emit state.
// Reset clears all slot valid flags at once; deadline and period storage is not cleared.
module multi_timer_scheduler #(
    parameter int TIMER_SLOTS = mts_pkg::TIMER_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // now[47:0], interval[79:48], repeating[80], target_id[85:81]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // slot_id[4:0], ok[5]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int SLOT_COUNT = (TIMER_SLOTS < mts_pkg::SLOT_MAX) ? TIMER_SLOTS
                                                                  : mts_pkg::SLOT_MAX;
    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);
    localparam logic [mts_pkg::SLOT_ID_W:0] SLOT_LIMIT = (mts_pkg::SLOT_ID_W + 1)'(SLOT_COUNT);
    localparam logic [mts_pkg::FIRE_CNT_W-1:0] FIRE_LAST =
        mts_pkg::FIRE_CNT_W'(mts_pkg::SLOT_MAX - 1);

    // Input field views.
    logic [mts_pkg::TIME_W-1:0]    in_now;
    logic [mts_pkg::PERIOD_W-1:0]  in_interval;
    logic                          in_repeating;
    logic [mts_pkg::SLOT_ID_W-1:0] in_target_id;

    assign in_now       = s_tdata[47:0];
    assign in_interval  = s_tdata[79:48];
    assign in_repeating = s_tdata[80];
    assign in_target_id = s_tdata[85:81];

    // Control and item registers.
    mts_pkg::state_t state_reg, state_next;
    mts_pkg::state_t ret_reg, ret_next;
    logic [mts_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [mts_pkg::PERIOD_W-1:0]  ival_reg, ival_next;
    logic                          rep_reg, rep_next;
    logic [mts_pkg::SLOT_ID_W-1:0] tid_reg, tid_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;
    logic                          found_reg, found_next;
    logic [IDX_W-1:0]              best_idx_reg, best_idx_next;
    logic [mts_pkg::TIME_W-1:0]    best_dl_reg, best_dl_next;
    logic [mts_pkg::PERIOD_W-1:0]  best_per_reg, best_per_next;
    logic [mts_pkg::TIME_W:0]      sum_reg, sum_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]              pend_idx_reg, pend_idx_next;
    logic [mts_pkg::FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;

    // Pending result beat.
    mts_pkg::kind_t                res_kind_reg, res_kind_next;
    logic [mts_pkg::SLOT_ID_W-1:0] res_id_reg, res_id_next;
    logic                          res_ok_reg, res_ok_next;
    logic                          res_last_reg, res_last_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    mts_pkg::kind_t                out_kind_reg, out_kind_next;
    logic [mts_pkg::SLOT_ID_W-1:0] out_id_reg, out_id_next;
    logic                          out_ok_reg, out_ok_next;
    logic                          out_last_reg, out_last_next;

    // Slot flags.
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] periodic_reg;
    logic                  valid_we;
    logic                  valid_wdata;
    logic [IDX_W-1:0]      valid_widx;
    logic                  periodic_we;

    // Memory and shared unit connections.
    mts_pkg::mem_req_t    mem_req;
    mts_pkg::slot_entry_t mem_rdata;
    mts_pkg::arith_in_t   arith_in;
    mts_pkg::arith_out_t  arith_out;

    logic                       in_accept;
    logic                       fire_done;
    logic                       hit;
    logic [mts_pkg::TIME_W-1:0] limit;

    mts_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    mts_arith u_arith (
        .op_in (arith_in),
        .res   (arith_out)
    );

    assign s_tready  = (state_reg == mts_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Shared unit operand selection by sequencer step.
    always_comb
    begin
        limit = found_reg ? best_dl_reg : now_reg;
        case (state_reg)
            mts_pkg::ST_ADD:
            begin
                arith_in.add_a = now_reg;
                arith_in.add_b = ival_reg;
            end
            mts_pkg::ST_FIRE:
            begin
                arith_in.add_a = best_dl_reg;
                arith_in.add_b = best_per_reg;
            end
            default:
            begin
                arith_in.add_a = now_reg;
                arith_in.add_b = mts_pkg::PERIOD_W'(1);
            end
        endcase
        if (state_reg == mts_pkg::ST_SCAN)
        begin
            arith_in.cmp_a = {1'b0, mem_rdata.deadline};
            arith_in.cmp_b = {1'b0, limit};
        end
        else
        begin
            arith_in.cmp_a = sum_reg;
            arith_in.cmp_b = {1'b0, now_reg};
        end
    end

    // A checked slot beats the current candidate: expired and strictly earlier.
    assign hit = chk_valid_reg && valid_reg[chk_idx_reg]
              && (found_reg ? arith_out.lt : (arith_out.lt || arith_out.eq));

    // Sequencer next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        now_next        = now_reg;
        ival_next       = ival_reg;
        rep_next        = rep_reg;
        tid_next        = tid_reg;
        cnt_next        = cnt_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        best_per_next   = best_per_reg;
        sum_next        = sum_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        res_kind_next   = res_kind_reg;
        res_id_next     = res_id_reg;
        res_ok_next     = res_ok_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_ok_next     = out_ok_reg;
        out_last_next   = out_last_reg;
        valid_we        = 1'b0;
        valid_wdata     = 1'b0;
        valid_widx      = best_idx_reg;
        periodic_we     = 1'b0;
        fire_done       = 1'b0;
        mem_req.we        = 1'b0;
        mem_req.waddr     = mts_pkg::SLOT_ID_W'(best_idx_reg);
        mem_req.wdeadline = arith_out.sum[mts_pkg::TIME_W-1:0];
        mem_req.wperiod   = best_per_reg;
        mem_req.raddr     = mts_pkg::SLOT_ID_W'(cnt_reg[IDX_W-1:0]);

        case (state_reg)
            // Take an item and dispatch on its operation.
            mts_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    now_next  = in_now;
                    ival_next = in_interval;
                    rep_next  = in_repeating;
                    tid_next  = in_target_id;
                    cnt_next  = '0;
                    found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    fire_cnt_next   = '0;
                    case (mts_pkg::op_t'(s_tuser))
                        mts_pkg::OP_ADD:    state_next = mts_pkg::ST_ADD;
                        mts_pkg::OP_REMOVE: state_next = mts_pkg::ST_REM;
                        mts_pkg::OP_TICK:   state_next = mts_pkg::ST_SCAN;
                        default:            state_next = mts_pkg::ST_IDLE;
                    endcase
                end
            end

            // Walk the valid flags for the lowest free slot.
            mts_pkg::ST_ADD:
            begin
                res_kind_next = mts_pkg::KIND_ADD;
                res_last_next = 1'b1;
                ret_next      = mts_pkg::ST_IDLE;
                if (!valid_reg[cnt_reg[IDX_W-1:0]])
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = mts_pkg::SLOT_ID_W'(cnt_reg[IDX_W-1:0]);
                    mem_req.wperiod = ival_reg;
                    valid_we      = 1'b1;
                    valid_wdata   = 1'b1;
                    valid_widx    = cnt_reg[IDX_W-1:0];
                    periodic_we   = 1'b1;
                    res_id_next   = mts_pkg::SLOT_ID_W'(cnt_reg[IDX_W-1:0]);
                    res_ok_next   = 1'b1;
                    state_next    = mts_pkg::ST_EMIT;
                end
                else if (cnt_reg == CNT_LAST)
                begin
                    res_id_next = '0;
                    res_ok_next = 1'b0;
                    state_next  = mts_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            // Free the target slot if it is in range and in use.
            mts_pkg::ST_REM:
            begin
                res_kind_next = mts_pkg::KIND_REMOVE;
                res_id_next   = tid_reg;
                res_last_next = 1'b1;
                res_ok_next   = 1'b0;
                ret_next      = mts_pkg::ST_IDLE;
                state_next    = mts_pkg::ST_EMIT;
                if (({1'b0, tid_reg} < SLOT_LIMIT) && valid_reg[tid_reg[IDX_W-1:0]])
                begin
                    res_ok_next = 1'b1;
                    valid_we    = 1'b1;
                    valid_wdata = 1'b0;
                    valid_widx  = tid_reg[IDX_W-1:0];
                end
            end

            // Walk the deadlines for the earliest expired slot.
            mts_pkg::ST_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = cnt_reg[IDX_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    found_next    = 1'b1;
                    best_idx_next = chk_idx_reg;
                    best_dl_next  = mem_rdata.deadline;
                    best_per_next = mem_rdata.period;
                end
                if ((cnt_reg == CNT_END) && !chk_valid_reg)
                begin
                    res_kind_next = mts_pkg::KIND_FIRED;
                    res_id_next   = mts_pkg::SLOT_ID_W'(pend_idx_reg);
                    res_ok_next   = 1'b1;
                    if (found_reg)
                    begin
                        // Another slot fires, so the held beat is not the last.
                        res_last_next = 1'b0;
                        ret_next      = mts_pkg::ST_FIRE;
                        state_next    = pend_valid_reg ? mts_pkg::ST_EMIT : mts_pkg::ST_FIRE;
                    end
                    else
                    begin
                        res_last_next = 1'b1;
                        ret_next      = mts_pkg::ST_IDLE;
                        state_next    = mts_pkg::ST_EMIT;
                        if (!pend_valid_reg)
                        begin
                            res_kind_next = mts_pkg::KIND_IDLE_TICK;
                            res_id_next   = '0;
                            res_ok_next   = 1'b0;
                        end
                    end
                end
            end

            // Fire the chosen slot: free a one-shot, start the periodic sum.
            mts_pkg::ST_FIRE:
            begin
                if (periodic_reg[best_idx_reg])
                begin
                    sum_next   = arith_out.sum;
                    state_next = mts_pkg::ST_RESCHED;
                end
                else
                begin
                    valid_we    = 1'b1;
                    valid_wdata = 1'b0;
                    fire_done   = 1'b1;
                end
            end

            // Write the new deadline, falling back to now plus one.
            mts_pkg::ST_RESCHED:
            begin
                mem_req.we = 1'b1;
                if (!(arith_out.lt || arith_out.eq))
                begin
                    mem_req.wdeadline = sum_reg[mts_pkg::TIME_W-1:0];
                end
                fire_done = 1'b1;
            end

            // Hand the held beat to the output register once it is free.
            mts_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_id_next    = res_id_reg;
                    out_ok_next    = res_ok_reg;
                    out_last_next  = res_last_reg;
                    state_next     = ret_reg;
                end
            end

            default:
            begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase

        // Common end of a firing: hold it, then stop at the result limit or scan again.
        if (fire_done)
        begin
            pend_valid_next = 1'b1;
            pend_idx_next   = best_idx_reg;
            fire_cnt_next   = fire_cnt_reg + mts_pkg::FIRE_CNT_W'(1);
            cnt_next        = '0;
            found_next      = 1'b0;
            if (fire_cnt_reg == FIRE_LAST)
            begin
                res_kind_next = mts_pkg::KIND_FIRED;
                res_id_next   = mts_pkg::SLOT_ID_W'(best_idx_reg);
                res_ok_next   = 1'b1;
                res_last_next = 1'b1;
                ret_next      = mts_pkg::ST_IDLE;
                state_next    = mts_pkg::ST_EMIT;
            end
            else
            begin
                state_next = mts_pkg::ST_SCAN;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mts_pkg::ST_IDLE;
            ret_reg        <= mts_pkg::ST_IDLE;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            fire_cnt_reg   <= '0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            fire_cnt_reg   <= fire_cnt_next;
            if (valid_we)
            begin
                valid_reg[valid_widx] <= valid_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        ival_reg     <= ival_next;
        rep_reg      <= rep_next;
        tid_reg      <= tid_next;
        chk_idx_reg  <= chk_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        best_per_reg <= best_per_next;
        sum_reg      <= sum_next;
        pend_idx_reg <= pend_idx_next;
        res_kind_reg <= res_kind_next;
        res_id_reg   <= res_id_next;
        res_ok_reg   <= res_ok_next;
        res_last_reg <= res_last_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
        if (periodic_we)
        begin
            periodic_reg[valid_widx] <= rep_reg;
        end
    end

    // Output beat.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_ok_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
